// ----- hw/rtl/timed_event_queue_core_macros.svh -----
// Assertion macros used by the timed event queue engine.
`ifndef TIMED_EVENT_QUEUE_CORE_MACROS_SVH
`define TIMED_EVENT_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TEQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TEQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define TEQ_ASSERT(lbl, clk, rstn, prop, msg)
`define TEQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ----- hw/rtl/teq_pkg.sv -----
// Package with the operation, result kind and error codes of the timed event queue.
package teq_pkg;

  typedef enum logic [1:0] {
    MODE_SCHEDULE = 2'd0,
    MODE_CANCEL   = 2'd1,
    MODE_RUN      = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_e;

  localparam logic [2:0] KIND_SCHEDULED   = 3'd0;
  localparam logic [2:0] KIND_FIRED       = 3'd1;
  localparam logic [2:0] KIND_STOPPED     = 3'd2;
  localparam logic [2:0] KIND_ERROR       = 3'd3;
  localparam logic [2:0] KIND_CANCEL_DONE = 3'd4;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_PAST  = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;
  localparam logic [1:0] ERR_EMPTY = 2'd3;

endpackage

// ----- hw/rtl/teq_channels.sv -----
// Valid/ready channel interfaces for requests into and results out of the queue.
interface teq_req_if #(
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 16,
  parameter int TAG_BITS  = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [TIME_BITS-1:0] time_req;
  logic [ID_BITS-1:0]   target_id;
  logic [TAG_BITS-1:0]  payload;

  modport source (output valid, mode, time_req, target_id, payload, input ready);
  modport sink   (input valid, mode, time_req, target_id, payload, output ready);
endinterface

interface teq_res_if #(
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 16,
  parameter int TAG_BITS  = 16
);
  logic                 valid;
  logic                 ready;
  logic [2:0]           kind;
  logic [ID_BITS-1:0]   result_id;
  logic [TIME_BITS-1:0] event_time;
  logic [TAG_BITS-1:0]  tag_out;
  logic [1:0]           error_code;
  logic                 last;

  modport source (output valid, kind, result_id, event_time, tag_out, error_code, last,
                  input ready);
  modport sink   (input valid, kind, result_id, event_time, tag_out, error_code, last,
                  output ready);
endinterface

// ----- hw/rtl/teq_front.sv -----
// Front end: accepts request beats, decodes the operation and queues it for the engine.
module teq_front #(
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 16,
  parameter int TAG_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  teq_req_if.sink              in_i,
  output logic                 op_valid_o,
  input  logic                 op_ready_i,
  output teq_pkg::mode_e       op_mode_o,
  output logic [TIME_BITS-1:0] op_time_o,
  output logic [ID_BITS-1:0]   op_id_o,
  output logic [TAG_BITS-1:0]  op_tag_o
);
  import teq_pkg::*;

  localparam int EW = 2 + TIME_BITS + ID_BITS + TAG_BITS;

  logic [EW-1:0] entry_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;
  logic          push, pop;
  logic [EW-1:0] head;

  assign in_i.ready = (count_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign op_valid_o = (count_q != 2'd0);
  assign pop        = op_valid_o && op_ready_i;
  assign head       = entry_q[rd_ptr_q];

  assign op_mode_o = mode_e'(head[EW-1 -: 2]);
  assign op_time_o = head[ID_BITS+TAG_BITS +: TIME_BITS];
  assign op_id_o   = head[TAG_BITS +: ID_BITS];
  assign op_tag_o  = head[TAG_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= {in_i.mode, in_i.time_req, in_i.target_id, in_i.payload};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- hw/rtl/teq_engine.sv -----
// Back end: slot store, one-slot-per-cycle scan and the result output register.
`include "timed_event_queue_core_macros.svh"
module teq_engine #(
  parameter int DEPTH     = 32,
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 16,
  parameter int TAG_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 op_valid_i,
  output logic                 op_ready_o,
  input  teq_pkg::mode_e       op_mode_i,
  input  logic [TIME_BITS-1:0] op_time_i,
  input  logic [ID_BITS-1:0]   op_id_i,
  input  logic [TAG_BITS-1:0]  op_tag_i,
  teq_res_if.source            out_o
);
  import teq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = TIME_BITS + ID_BITS + TAG_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE, ST_EMIT} state_e;

  state_e               st_q;
  mode_e                mode_q;
  logic [TIME_BITS-1:0] treq_q, present_q, best_time_q, e_time_q, o_time_q;
  logic [ID_BITS-1:0]   eid_q, sid_q, nid_q, best_id_q, e_id_q, o_id_q;
  logic [TAG_BITS-1:0]  tag_q, best_tag_q, e_tag_q, o_tag_q;
  logic [DEPTH-1:0]     used_q, active_q;
  logic [CW-1:0]        cnt_q;
  logic                 pv_q, found_q, cont_q;
  logic [IW-1:0]        pidx_q, best_idx_q;
  logic [2:0]           e_kind_q, o_kind_q;
  logic [1:0]           e_err_q, o_err_q;
  logic                 e_last_q, o_last_q, ov_q;

  logic [MW-1:0]        mem [DEPTH];
  logic [MW-1:0]        rdata_q;
  logic                 issue, we, load, accept, acc_clear, hit;
  logic [IW-1:0]        rd_addr;
  logic [TIME_BITS-1:0] r_time;
  logic [ID_BITS-1:0]   r_id;
  logic [TAG_BITS-1:0]  r_tag;

  assign op_ready_o = (st_q == ST_IDLE);
  assign accept     = op_valid_i && op_ready_o;
  assign acc_clear  = accept && (op_mode_i == MODE_CLEAR);
  assign issue      = (st_q == ST_SCAN) && (cnt_q < CW'(DEPTH));
  assign rd_addr    = issue ? cnt_q[IW-1:0] : '0;
  assign we         = (st_q == ST_DECIDE) && (mode_q == MODE_SCHEDULE) && found_q;
  assign load       = (st_q == ST_EMIT) && (!ov_q || out_o.ready);

  assign r_time = rdata_q[MW-1 -: TIME_BITS];
  assign r_id   = rdata_q[TAG_BITS +: ID_BITS];
  assign r_tag  = rdata_q[TAG_BITS-1:0];

  always_comb begin
    unique case (mode_q)
      MODE_SCHEDULE: hit = !found_q && !used_q[pidx_q];
      MODE_CANCEL:   hit = !found_q && used_q[pidx_q] && (r_id == eid_q);
      MODE_RUN:      hit = used_q[pidx_q] && (!found_q || (r_time < best_time_q) ||
                           ((r_time == best_time_q) && (r_id < best_id_q)));
      default:       hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[best_idx_q] <= {treq_q, sid_q, tag_q};
    end
    rdata_q <= mem[rd_addr];
  end

  assign out_o.valid      = ov_q;
  assign out_o.kind       = o_kind_q;
  assign out_o.result_id  = o_id_q;
  assign out_o.event_time = o_time_q;
  assign out_o.tag_out    = o_tag_q;
  assign out_o.error_code = o_err_q;
  assign out_o.last       = o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      used_q    <= '0;
      active_q  <= '0;
      present_q <= '0;
      nid_q     <= '0;
      cnt_q     <= '0;
      pv_q      <= 1'b0;
      found_q   <= 1'b0;
      cont_q    <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      if (ov_q && out_o.ready) ov_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: begin
          if (accept) begin
            mode_q  <= op_mode_i;
            treq_q  <= op_time_i;
            eid_q   <= op_id_i;
            tag_q   <= op_tag_i;
            cnt_q   <= '0;
            pv_q    <= 1'b0;
            found_q <= 1'b0;
            cont_q  <= 1'b0;
            unique case (op_mode_i)
              MODE_SCHEDULE: begin
                sid_q <= nid_q;
                nid_q <= nid_q + ID_BITS'(1);
                if (op_time_i < present_q) begin
                  e_kind_q <= KIND_ERROR;
                  e_id_q   <= nid_q;
                  e_time_q <= '0;
                  e_tag_q  <= '0;
                  e_err_q  <= ERR_PAST;
                  e_last_q <= 1'b1;
                  st_q     <= ST_EMIT;
                end else begin
                  st_q <= ST_SCAN;
                end
              end
              MODE_CANCEL, MODE_RUN: st_q <= ST_SCAN;
              default: begin
                used_q    <= '0;
                active_q  <= '0;
                present_q <= '0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (issue) begin
            cnt_q  <= cnt_q + CW'(1);
            pidx_q <= cnt_q[IW-1:0];
          end
          pv_q <= issue;
          if (pv_q && hit) begin
            found_q     <= 1'b1;
            best_idx_q  <= pidx_q;
            best_time_q <= r_time;
            best_id_q   <= r_id;
            best_tag_q  <= r_tag;
            if (mode_q == MODE_CANCEL) active_q[pidx_q] <= 1'b0;
          end
          if (!issue && !pv_q) st_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          e_time_q <= '0;
          e_tag_q  <= '0;
          e_err_q  <= ERR_NONE;
          e_last_q <= 1'b1;
          cont_q   <= 1'b0;
          st_q     <= ST_EMIT;
          unique case (mode_q)
            MODE_SCHEDULE: begin
              e_id_q <= sid_q;
              if (found_q) begin
                used_q[best_idx_q]   <= 1'b1;
                active_q[best_idx_q] <= 1'b1;
                e_kind_q             <= KIND_SCHEDULED;
              end else begin
                e_kind_q <= KIND_ERROR;
                e_err_q  <= ERR_FULL;
              end
            end
            MODE_CANCEL: begin
              e_kind_q <= KIND_CANCEL_DONE;
              e_id_q   <= eid_q;
            end
            default: begin
              if (!found_q) begin
                e_kind_q <= KIND_ERROR;
                e_id_q   <= '0;
                e_err_q  <= ERR_EMPTY;
              end else if (best_time_q > treq_q) begin
                e_kind_q <= KIND_STOPPED;
                e_id_q   <= best_id_q;
                e_time_q <= best_time_q;
                e_tag_q  <= best_tag_q;
              end else begin
                used_q[best_idx_q] <= 1'b0;
                present_q          <= best_time_q;
                cnt_q              <= '0;
                found_q            <= 1'b0;
                if (active_q[best_idx_q]) begin
                  active_q[best_idx_q] <= 1'b0;
                  e_kind_q             <= KIND_FIRED;
                  e_id_q               <= best_id_q;
                  e_time_q             <= best_time_q;
                  e_tag_q              <= best_tag_q;
                  e_last_q             <= 1'b0;
                  cont_q               <= 1'b1;
                end else begin
                  st_q <= ST_SCAN;
                end
              end
            end
          endcase
        end
        default: begin
          if (load) begin
            ov_q     <= 1'b1;
            o_kind_q <= e_kind_q;
            o_id_q   <= e_id_q;
            o_time_q <= e_time_q;
            o_tag_q  <= e_tag_q;
            o_err_q  <= e_err_q;
            o_last_q <= e_last_q;
            st_q     <= cont_q ? ST_SCAN : ST_IDLE;
          end
        end
      endcase
    end
  end

  `TEQ_ASSERT(a_load_free, clk_i, rst_ni, load |-> (!ov_q || out_o.ready),
              "result register overwritten")
  `TEQ_ASSERT(a_present_src, clk_i, rst_ni,
              !$stable(present_q) |-> ($past(st_q) == ST_DECIDE || $past(acc_clear)),
              "present time changed outside a run or clear")
  `TEQ_ASSERT_NEVER(a_fired_limit, clk_i, rst_ni,
                    load && (e_kind_q == KIND_FIRED) && (e_time_q > treq_q),
                    "fired event beyond run limit")

endmodule

// ----- hw/rtl/timed_event_queue_core.sv -----
// A schedule or cancel result follows a scan of every slot of the store; a schedule in the
// past answers without a scan. A run gives its first result after a full scan, then scans
// the store again for each fired or dropped event.
// The engine finishes one request before it takes the next; a two-entry queue takes further beats
// meanwhile, and the engine waits only while the output register holds an untaken result.
// Reset clears control, present time and the id counter; slot contents need no clearing pass.
module timed_event_queue_core #(
  parameter int DEPTH     = 32,
  parameter int TIME_BITS = 32,
  parameter int ID_BITS   = 16,
  parameter int TAG_BITS  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  teq_req_if.sink   in_i,
  teq_res_if.source out_o
);
  import teq_pkg::*;

  // Decoded operation passed from the front end to the engine.
  logic                 op_valid, op_ready;
  mode_e                op_mode;
  logic [TIME_BITS-1:0] op_time;
  logic [ID_BITS-1:0]   op_id;
  logic [TAG_BITS-1:0]  op_tag;

  // The front end takes request beats into a short queue so that a new beat
  // can arrive while the engine is still scanning the store.
  teq_front #(
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS),
    .TAG_BITS  (TAG_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .op_valid_o (op_valid),
    .op_ready_i (op_ready),
    .op_mode_o  (op_mode),
    .op_time_o  (op_time),
    .op_id_o    (op_id),
    .op_tag_o   (op_tag)
  );

  // The engine owns the slot store and walks it one slot per cycle, looking
  // for a free slot, a matching id or the earliest event. Each result beat
  // leaves through an output register, so a stalled sink only holds the engine
  // when a second result is ready to go.
  teq_engine #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS),
    .TAG_BITS  (TAG_BITS)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_valid_i (op_valid),
    .op_ready_o (op_ready),
    .op_mode_i  (op_mode),
    .op_time_i  (op_time),
    .op_id_i    (op_id),
    .op_tag_i   (op_tag),
    .out_o      (out_o)
  );

endmodule

// ----- bench/timed_event_queue_core_tb.sv -----
// Self-checking testbench for the timed event queue: directed, random and back-pressure tests.
`timescale 1ns / 100ps

module timed_event_queue_core_tb;
  import teq_pkg::*;

  localparam int DEPTH = 32;

  // One expected result beat of the queue.
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] result_id;
    logic [31:0] event_time;
    logic [15:0] tag_out;
    logic [1:0]  error_code;
    logic        last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  teq_req_if req_if ();
  teq_res_if res_if ();

  timed_event_queue_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (res_if.source)
  );

  // Shadow copy of the event store, kept in step with every accepted request beat.
  logic [31:0] ev_time [DEPTH];
  logic [15:0] ev_id   [DEPTH];
  logic [15:0] ev_tag  [DEPTH];
  logic        ev_live [DEPTH];
  logic        ev_used [DEPTH];
  logic [31:0] now_time;
  logic [15:0] id_count;

  result_t expected_results[$];
  int      failures;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_off_cycles;

  function automatic result_t mk(logic [2:0] k, logic [15:0] id, logic [31:0] t,
                                 logic [15:0] tg, logic [1:0] e, logic l);
    result_t r;
    r.kind = k; r.result_id = id; r.event_time = t; r.tag_out = tg;
    r.error_code = e; r.last = l;
    return r;
  endfunction

  // Works out the result beats that one request causes and updates the shadow store.
  task automatic predict_queue(mode_e m, logic [31:0] t, logic [15:0] eid, logic [15:0] tg);
    logic [15:0] id;
    int          slot;
    int          best;
    case (m)
      MODE_SCHEDULE: begin
        id = id_count;
        id_count = id_count + 16'd1;
        slot = -1;
        for (int i = DEPTH - 1; i >= 0; i--) if (!ev_used[i]) slot = i;
        if (t < now_time) begin
          expected_results.push_back(mk(KIND_ERROR, id, '0, '0, ERR_PAST, 1'b1));
        end else if (slot < 0) begin
          expected_results.push_back(mk(KIND_ERROR, id, '0, '0, ERR_FULL, 1'b1));
        end else begin
          ev_time[slot] = t; ev_id[slot] = id; ev_tag[slot] = tg;
          ev_live[slot] = 1'b1; ev_used[slot] = 1'b1;
          expected_results.push_back(mk(KIND_SCHEDULED, id, '0, '0, ERR_NONE, 1'b1));
        end
      end
      MODE_CANCEL: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (ev_used[i] && ev_id[i] == eid) begin
            ev_live[i] = 1'b0;
            break;
          end
        end
        expected_results.push_back(mk(KIND_CANCEL_DONE, eid, '0, '0, ERR_NONE, 1'b1));
      end
      MODE_RUN: begin
        forever begin
          best = -1;
          for (int i = 0; i < DEPTH; i++) begin
            if (ev_used[i] && (best < 0 || ev_time[i] < ev_time[best] ||
                (ev_time[i] == ev_time[best] && ev_id[i] < ev_id[best])))
              best = i;
          end
          if (best < 0) begin
            expected_results.push_back(mk(KIND_ERROR, '0, '0, '0, ERR_EMPTY, 1'b1));
            break;
          end
          if (ev_time[best] > t) begin
            expected_results.push_back(mk(KIND_STOPPED, ev_id[best], ev_time[best],
                                          ev_tag[best], ERR_NONE, 1'b1));
            break;
          end
          ev_used[best] = 1'b0;
          now_time = ev_time[best];
          if (ev_live[best]) begin
            ev_live[best] = 1'b0;
            expected_results.push_back(mk(KIND_FIRED, ev_id[best], ev_time[best],
                                          ev_tag[best], ERR_NONE, 1'b0));
          end
        end
      end
      default: begin
        for (int i = 0; i < DEPTH; i++) begin
          ev_used[i] = 1'b0;
          ev_live[i] = 1'b0;
        end
        now_time = '0;
      end
    endcase
  endtask

  // Offers one request beat and predicts on acceptance. Valid stays high on return, so a
  // following beat goes out straight away; an idle gap or the drain lowers it.
  task automatic send_request(mode_e m, logic [31:0] t, logic [15:0] eid, logic [15:0] tg);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.mode      <= m;
    req_if.time_req  <= t;
    req_if.target_id <= eid;
    req_if.payload   <= tg;
    do @(posedge clk_i); while (!req_if.ready);
    predict_queue(m, t, eid, tg);
    @(negedge clk_i);
  endtask

  // Stops offering, waits until every expected beat has come back, then lets the block settle.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: compares each beat with the oldest expectation, field by field.
  always @(posedge clk_i) begin
    result_t got;
    result_t exp_r;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = mk(res_if.kind, res_if.result_id, res_if.event_time, res_if.tag_out,
               res_if.error_code, res_if.last);
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat %p", $realtime, got);
        failures++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
          failures++;
        end
      end
    end
  end

  // A schedule mostly near the present time, sometimes in the past or anywhere, so that runs have work to do.
  task automatic random_schedule();
    logic [31:0] t;
    case ($urandom_range(9))
      0: t = $urandom;
      1: t = now_time - $urandom_range(1, 20);
      default: t = now_time + $urandom_range(0, 60);
    endcase
    send_request(MODE_SCHEDULE, t, 16'($urandom), 16'($urandom));
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(99);
    if (r < 50) random_schedule();
    else if (r < 65) send_request(MODE_CANCEL, $urandom,
                                  16'(id_count - $urandom_range(1, 40)), 16'($urandom));
    else if (r < 70) send_request(MODE_CANCEL, $urandom, 16'($urandom), 16'($urandom));
    else if (r < 97) send_request(MODE_RUN, now_time + $urandom_range(0, 80), 16'($urandom),
                                  16'($urandom));
    else send_request(MODE_CLEAR, $urandom, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    send_request(MODE_RUN, 32'hFFFF_FFFF, 16'h0, 16'h0);               // empty store
    send_request(MODE_CANCEL, 32'h0, 16'hFFFF, 16'hFFFF);              // no match
    send_request(MODE_SCHEDULE, 32'd10, 16'h0, 16'hFFFF);
    send_request(MODE_SCHEDULE, 32'd10, 16'h0, 16'h0000);              // tie on time
    send_request(MODE_SCHEDULE, 32'hFFFF_FFFF, 16'hFFFF, 16'hA5A5);
    send_request(MODE_SCHEDULE, 32'd0, 16'h0, 16'h5A5A);
    send_request(MODE_CANCEL, 32'h0, 16'd3, 16'h0);                    // cancelled event
    send_request(MODE_CANCEL, 32'h0, 16'd3, 16'h0);                    // already inactive
    send_request(MODE_RUN, 32'd9, 16'h0, 16'h0);                       // dropped, then stop
    send_request(MODE_RUN, 32'd10, 16'h0, 16'h0);                      // tie by lower id
    send_request(MODE_SCHEDULE, 32'd5, 16'h0, 16'h0);                  // in the past
    send_request(MODE_RUN, 32'hFFFF_FFFF, 16'h0, 16'h0);               // fires, then empty
    send_request(MODE_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i <= DEPTH; i++)                                   // fill, then full
      send_request(MODE_SCHEDULE, 32'd100 - i, 16'(i), 16'(i));
    send_request(MODE_RUN, 32'hFFFF_FFFF, 16'h0, 16'h0);               // longest run
    drain_results();
  endtask

  task automatic test_random(int n_items);
    for (int i = 0; i < n_items; i++) random_request();
    drain_results();
  endtask

  // The receiver holds off while the sender keeps offering, so the block backs up.
  task automatic test_back_pressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(negedge clk_i);
    hold_off_cycles <= 400;
    for (int i = 0; i < 10; i++) random_schedule();
    drain_results();
  endtask

  initial begin
    req_if.valid = 1'b0; req_if.mode = MODE_SCHEDULE;
    req_if.time_req = '0; req_if.target_id = '0; req_if.payload = '0;
    res_if.ready = 1'b0;
    failures = 0; send_idle_pct = 0; recv_stall_pct = 0; hold_off_cycles = 0;
    for (int i = 0; i < DEPTH; i++) begin
      ev_used[i] = 1'b0; ev_live[i] = 1'b0;
    end
    now_time = '0; id_count = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(120);
    send_idle_pct = 86; recv_stall_pct = 0;
    test_random(100);
    send_idle_pct = 0; recv_stall_pct = 86;
    test_random(100);
    send_idle_pct = 26; recv_stall_pct = 26;
    test_random(100);
    test_back_pressure();

    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
